// ----- rtl/tsw_pkg.sv -----
// Shared types and constants for the TDMA slot wait calculator.
package tsw_pkg;

  // Time and divider operand width
  localparam int unsigned TimeW  = 32;
  localparam int unsigned LenW   = 16;
  localparam int unsigned SlotW  = 8;
  localparam int unsigned ProdW  = SlotW + LenW;
  localparam int unsigned CurW   = 9;
  localparam int unsigned StatW  = 2;
  localparam int unsigned CntW   = $clog2(TimeW);

  // Configuration register indexes
  typedef enum logic [1:0] {
    RegPeriod  = 2'd0,
    RegSlotLen = 2'd1,
    RegSlotCnt = 2'd2,
    RegNone    = 2'd3
  } reg_idx_e;

  // Result status codes
  typedef enum logic [StatW-1:0] {
    StatOk      = 2'd0,
    StatNoWin   = 2'd1,
    StatBadSlot = 2'd2
  } status_e;

  // Sequencer states
  typedef enum logic [2:0] {
    SIdle,
    SDivPer,
    SUpdate,
    SCheck,
    SDivSlot,
    SSelect,
    SSum,
    SOut
  } state_e;

endpackage

// ----- rtl/tsw_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
module tsw_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [tsw_pkg::TimeW-1:0] dividend_i,
  input  logic [tsw_pkg::TimeW-1:0] divisor_i,
  output logic                      done_o,
  output logic [tsw_pkg::TimeW-1:0] quotient_o,
  output logic [tsw_pkg::TimeW-1:0] remainder_o
);
  import tsw_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [TimeW-1:0]  dvd_q, dvd_d;
  logic [TimeW-1:0]  rem_q, rem_d;
  logic [TimeW-1:0]  dvs_q, dvs_d;
  logic [TimeW:0]    trial;
  logic [TimeW:0]    diff;
  logic              qbit;

  // Shift in one dividend bit and try the subtract
  always_comb begin
    trial = {rem_q, dvd_q[TimeW-1]};
    diff  = trial - {1'b0, dvs_q};
    qbit  = (trial >= {1'b0, dvs_q});
  end

  // Advance one step per cycle while busy
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(TimeW - 1);
      dvd_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      dvd_d = {dvd_q[TimeW-2:0], qbit};
      rem_d = qbit ? diff[TimeW-1:0] : trial[TimeW-1:0];
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = dvd_q;
  assign remainder_o = rem_q;

endmodule

// ----- rtl/tdma_slot_wait_calculator.sv -----
// Top level of the TDMA slot wait calculator: sequencer, window state and registers.
//
// Usage: the input channel (in_valid_i / in_ready_o) takes one item holding
// now_time_i and target_slot_i. The output channel (out_valid_o / out_ready_i)
// gives one item per input item: active_slot_o, wait_seconds_o, wake_time_o
// and status_o. The APB-style port writes superframe_period (0x0),
// slot_length (0x4) and slot_count (0x8); pready is always high.
// Sequencing: an invalid target slot goes straight to the output state. A valid
// item runs one 32-step division for the superframe remainder and, when inside
// the window, a second 32-step division for the slot index, both on one shared
// restoring divider, then passes the select and sum states to the output state.
// in_ready_o is high only while the sequencer is idle, one item at a time.
// A finished result sits in an output register, so the next item is taken
// while it waits; a stalled receiver holds the result and the sequencer
// waits before loading the following one.
// Reset: registers return to period 60, slot length 1, slot count 1; the
// window start and end clear to 0; no result is pending.
module tdma_slot_wait_calculator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input item channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [tsw_pkg::TimeW-1:0]         now_time_i,
  input  logic [tsw_pkg::SlotW-1:0]         target_slot_i,
  // result item channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [tsw_pkg::CurW-1:0]   active_slot_o,
  output logic [tsw_pkg::TimeW-1:0]         wait_seconds_o,
  output logic [tsw_pkg::TimeW-1:0]         wake_time_o,
  output logic [tsw_pkg::StatW-1:0]         status_o,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [3:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import tsw_pkg::*;

  // Configuration registers
  logic [TimeW-1:0] period_q;
  logic [LenW-1:0]  slot_len_q;
  logic [SlotW-1:0] slot_cnt_q;
  reg_idx_e         reg_idx;

  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q   <= TimeW'(60);
      slot_len_q <= LenW'(1);
      slot_cnt_q <= SlotW'(1);
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        RegPeriod:  period_q   <= pwdata[TimeW-1:0];
        RegSlotLen: slot_len_q <= pwdata[LenW-1:0];
        RegSlotCnt: slot_cnt_q <= pwdata[SlotW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegPeriod:  prdata = period_q;
      RegSlotLen: prdata = {16'd0, slot_len_q};
      RegSlotCnt: prdata = {24'd0, slot_cnt_q};
      default:    prdata = '0;
    endcase
  end

  // Sequencer and working registers
  state_e           state_q, state_d;
  logic [TimeW-1:0] ws_q, ws_d;
  logic [TimeW-1:0] we_q, we_d;
  logic [TimeW-1:0] now_q, now_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic             bad_q, bad_d;
  logic [TimeW-1:0] nm_q, nm_d;
  logic             in_win_q, in_win_d;
  logic [SlotW-1:0] cur_q, cur_d;
  logic [TimeW-1:0] base_q, base_d;
  logic [ProdW-1:0] prod_q, prod_d;
  logic             zero_q, zero_d;
  logic [TimeW-1:0] wait_q, wait_d;

  logic                   out_valid_q, out_valid_d;
  logic [CurW-1:0]        out_cur_q, out_cur_d;
  logic [TimeW-1:0]       out_wait_q, out_wait_d;
  logic [TimeW-1:0]       out_wake_q, out_wake_d;
  status_e                out_stat_q, out_stat_d;

  // Shared divider
  logic             div_start;
  logic [TimeW-1:0] div_dvd;
  logic [TimeW-1:0] div_dvs;
  logic             div_done;
  logic [TimeW-1:0] div_quot;
  logic [TimeW-1:0] div_rem;

  tsw_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dvd),
    .divisor_i   (div_dvs),
    .done_o      (div_done),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  // Shared slot-length multiplier
  logic [SlotW-1:0] mul_a;
  logic [ProdW-1:0] mul_p;
  logic [LenW-1:0]  len;
  logic [SlotW-1:0] cur_sat;
  logic             far;
  logic [SlotW-1:0] left;

  assign mul_p = ProdW'(mul_a) * ProdW'(slot_len_q);
  assign len   = (slot_len_q == '0) ? LenW'(1) : slot_len_q;

  always_comb begin
    state_d     = state_q;
    ws_d        = ws_q;
    we_d        = we_q;
    now_d       = now_q;
    slot_d      = slot_q;
    bad_d       = bad_q;
    nm_d        = nm_q;
    in_win_d    = in_win_q;
    cur_d       = cur_q;
    base_d      = base_q;
    prod_d      = prod_q;
    zero_d      = zero_q;
    wait_d      = wait_q;
    out_valid_d = out_valid_q;
    out_cur_d   = out_cur_q;
    out_wait_d  = out_wait_q;
    out_wake_d  = out_wake_q;
    out_stat_d  = out_stat_q;
    div_start   = 1'b0;
    div_dvd     = now_time_i;
    div_dvs     = period_q;
    mul_a       = slot_cnt_q;
    in_ready_o  = (state_q == SIdle);

    cur_sat = (|div_quot[TimeW-1:SlotW]) ? {SlotW{1'b1}} : div_quot[SlotW-1:0];
    if (!in_win_q) begin
      cur_sat = '0;
    end
    far  = !in_win_q || (slot_q < cur_sat);
    left = slot_q - cur_sat;

    // Drop the result once the receiver takes it
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          now_d  = now_time_i;
          slot_d = target_slot_i;
          if (target_slot_i >= slot_cnt_q) begin
            bad_d   = 1'b1;
            state_d = SOut;
          end else begin
            bad_d     = 1'b0;
            div_start = 1'b1;
            state_d   = SDivPer;
          end
        end
      end
      SDivPer: begin
        // Next superframe boundary at or after now
        if (div_done) begin
          if (period_q == '0) begin
            nm_d = '0;
          end else if (div_rem == '0) begin
            nm_d = now_q;
          end else begin
            nm_d = now_q - div_rem + period_q;
          end
          state_d = SUpdate;
        end
      end
      SUpdate: begin
        // Move the window once now has reached its end
        mul_a = slot_cnt_q;
        if (now_q >= we_q) begin
          ws_d = nm_q;
          we_d = nm_q + TimeW'(mul_p);
        end
        state_d = SCheck;
      end
      SCheck: begin
        in_win_d = (now_q >= ws_q) && (now_q < we_q);
        if ((now_q >= ws_q) && (now_q < we_q)) begin
          div_start = 1'b1;
          div_dvd   = now_q - ws_q;
          div_dvs   = TimeW'(len);
          state_d   = SDivSlot;
        end else begin
          state_d = SSelect;
        end
      end
      SDivSlot: begin
        if (div_done) begin
          state_d = SSelect;
        end
      end
      SSelect: begin
        // Pick the wait formula and form its two terms
        cur_d = cur_sat;
        if (far) begin
          mul_a  = slot_q;
          base_d = nm_q - now_q;
          zero_d = 1'b0;
        end else begin
          mul_a  = left - SlotW'(1);
          base_d = TimeW'(len) - div_rem;
          zero_d = (left == '0);
        end
        prod_d  = mul_p;
        state_d = SSum;
      end
      SSum: begin
        wait_d  = zero_q ? '0 : base_q + TimeW'(prod_q);
        state_d = SOut;
      end
      SOut: begin
        // Load the output register once it is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          if (bad_q) begin
            out_cur_d  = '0;
            out_wait_d = '0;
            out_wake_d = '0;
            out_stat_d = StatBadSlot;
          end else begin
            out_cur_d  = in_win_q ? {1'b0, cur_q} : {CurW{1'b1}};
            out_wait_d = wait_q;
            out_wake_d = now_q + wait_q;
            out_stat_d = in_win_q ? StatOk : StatNoWin;
          end
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      ws_q        <= '0;
      we_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ws_q        <= ws_d;
      we_q        <= we_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q      <= now_d;
    slot_q     <= slot_d;
    bad_q      <= bad_d;
    nm_q       <= nm_d;
    in_win_q   <= in_win_d;
    cur_q      <= cur_d;
    base_q     <= base_d;
    prod_q     <= prod_d;
    zero_q     <= zero_d;
    wait_q     <= wait_d;
    out_cur_q  <= out_cur_d;
    out_wait_q <= out_wait_d;
    out_wake_q <= out_wake_d;
    out_stat_q <= out_stat_d;
  end

  assign out_valid_o    = out_valid_q;
  assign active_slot_o  = signed'(out_cur_q);
  assign wait_seconds_o = out_wait_q;
  assign wake_time_o    = out_wake_q;
  assign status_o       = out_stat_q;

endmodule

// ----- dv/tb_tdma_slot_wait_calculator.sv -----
// Self-checking testbench for the TDMA slot wait calculator: directed and random queries.
module tb_tdma_slot_wait_calculator;
  import tsw_pkg::*;

  localparam int unsigned SettleCycles  = 80;
  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned NumPhases     = 10;
  localparam int unsigned PhaseItems    = 140;
  localparam logic signed [CurW-1:0] NoSlot = -9'sd1;

  // One result item as the block should report it
  typedef struct {
    logic signed [CurW-1:0] cur;
    logic [TimeW-1:0]       wait_sec;
    logic [TimeW-1:0]       wake;
    status_e                stat;
  } slot_result_t;

  // Window tracker and store of due results
  class slot_wait_scoreboard;
    logic [TimeW-1:0] period;
    logic [LenW-1:0]  slot_len;
    logic [SlotW-1:0] slot_cnt;
    logic [TimeW-1:0] win_start;
    logic [TimeW-1:0] win_end;
    slot_result_t     due_results[$];
    int unsigned      errors;

    function new();
      period    = 32'd60;
      slot_len  = 16'd1;
      slot_cnt  = 8'd1;
      win_start = '0;
      win_end   = '0;
      errors    = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [31:0] value);
      case (idx)
        RegPeriod:  period   = value;
        RegSlotLen: slot_len = value[LenW-1:0];
        RegSlotCnt: slot_cnt = value[SlotW-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return due_results.size();
    endfunction

    // First superframe boundary at or after t, wrapping at 32 bits
    function logic [TimeW-1:0] next_boundary(logic [TimeW-1:0] t);
      logic [TimeW-1:0] rem;
      if (period == 0) return '0;
      rem = t % period;
      if (rem == 0) return t;
      return t - rem + period;
    endfunction

    // Advance the window for an accepted query and queue its result
    function void note_query(logic [TimeW-1:0] now, logic [SlotW-1:0] slot);
      slot_result_t     r;
      logic [TimeW-1:0] dlen;
      logic [TimeW-1:0] idx;
      logic [TimeW-1:0] elapsed;
      bit               in_win;
      if (slot >= slot_cnt) begin
        r.cur      = '0;
        r.wait_sec = '0;
        r.wake     = '0;
        r.stat     = StatBadSlot;
        due_results.push_back(r);
        return;
      end
      // a zero slot length divides as one
      dlen = (slot_len == 0) ? 32'd1 : 32'(slot_len);
      if (now >= win_end) begin
        win_start = next_boundary(now);
        win_end   = win_start + 32'(slot_cnt) * 32'(slot_len);
      end
      in_win = (now >= win_start) && (now < win_end);
      idx = '0;
      if (in_win) begin
        idx = (now - win_start) / dlen;
        if (idx > 255) idx = 255;
      end
      if (!in_win || 32'(slot) < idx) begin
        r.wait_sec = next_boundary(now) - now + 32'(slot) * 32'(slot_len);
      end else if (32'(slot) == idx) begin
        r.wait_sec = '0;
      end else begin
        elapsed    = now - win_start;
        r.wait_sec = dlen - (elapsed % dlen) + (32'(slot) - idx - 1) * 32'(slot_len);
      end
      r.wake = now + r.wait_sec;
      r.cur  = in_win ? CurW'(idx) : NoSlot;
      r.stat = in_win ? StatOk : StatNoWin;
      due_results.push_back(r);
    endfunction

    // Compare one accepted result with the oldest due one
    function void check_result(slot_result_t got);
      slot_result_t exp;
      if (due_results.size() == 0) begin
        $error("result item with no query pending");
        errors++;
        return;
      end
      exp = due_results.pop_front();
      if (got.cur !== exp.cur) begin
        $error("active_slot: expected %0d, got %0d", exp.cur, got.cur);
        errors++;
      end
      if (got.wait_sec !== exp.wait_sec) begin
        $error("wait_seconds: expected %0d, got %0d", exp.wait_sec, got.wait_sec);
        errors++;
      end
      if (got.wake !== exp.wake) begin
        $error("wake_time: expected %0d, got %0d", exp.wake, got.wake);
        errors++;
      end
      if (got.stat !== exp.stat) begin
        $error("status: expected %0d, got %0d", exp.stat, got.stat);
        errors++;
      end
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic [TimeW-1:0]       now_time_i;
  logic [SlotW-1:0]       target_slot_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic signed [CurW-1:0] active_slot_o;
  logic [TimeW-1:0]       wait_seconds_o;
  logic [TimeW-1:0]       wake_time_o;
  logic [StatW-1:0]       status_o;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [3:0]             paddr;
  logic [31:0]            pwdata;
  logic [31:0]            prdata;
  logic                   pready;

  slot_wait_scoreboard sb;
  int unsigned         tx_gap_max;
  int unsigned         rx_gap_max;
  bit                  hold_start;
  logic                hold_rx;
  int unsigned         idle_cycles;

  tdma_slot_wait_calculator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .now_time_i    (now_time_i),
    .target_slot_i (target_slot_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .active_slot_o (active_slot_o),
    .wait_seconds_o(wait_seconds_o),
    .wake_time_o   (wake_time_o),
    .status_o      (status_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Hold off the receiver once for a long stretch
  initial begin : rx_holdoff
    hold_rx = 1'b0;
    wait (hold_start);
    @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  // Accept result items with random stalls and check each one
  initial begin : result_sink
    int unsigned  gap;
    slot_result_t got;
    gap         = 0;
    out_ready_i = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got.cur      = active_slot_o;
        got.wait_sec = wait_seconds_o;
        got.wake     = wake_time_o;
        got.stat     = status_e'(status_o);
        sb.check_result(got);
        gap = $urandom_range(0, rx_gap_max);
      end
      if (hold_rx) begin
        out_ready_i <= 1'b0;
      end else if (gap != 0) begin
        gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Offer one query item after a random gap and hold it until accepted
  task automatic send_query(input logic [TimeW-1:0] now, input logic [SlotW-1:0] slot);
    int unsigned gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    now_time_i    <= now;
    target_slot_i <= slot;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_query(now, slot);
  endtask

  // Stop offering and wait for every due result
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Drain, then let the sequencer finish any trailing work
  task automatic quiesce();
    drain_results();
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write one register, then read it back
  task automatic write_reg(input reg_idx_e idx, input logic [31:0] value);
    logic [31:0] mask;
    case (idx)
      RegPeriod:  mask = 32'hFFFF_FFFF;
      RegSlotLen: mask = 32'h0000_FFFF;
      RegSlotCnt: mask = 32'h0000_00FF;
      default:    mask = 32'h0;
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, value);
    // turn the same select into a read
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if ((prdata & mask) !== (value & mask)) begin
      $error("register %s: expected %0h, got %0h", idx.name(), value & mask, prdata & mask);
      sb.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_config(input logic [31:0] per, input logic [15:0] len,
                              input logic [7:0] cnt);
    quiesce();
    write_reg(RegPeriod, per);
    write_reg(RegSlotLen, 32'(len));
    write_reg(RegSlotCnt, 32'(cnt));
  endtask

  initial begin : stimulus
    logic [31:0] per;
    logic [15:0] len;
    logic [7:0]  cnt;
    logic [31:0] t;
    logic [31:0] now;
    logic [7:0]  slot;
    logic [63:0] span;
    int unsigned pick;
    int unsigned items;
    sb            = new();
    tx_gap_max    = 11;
    rx_gap_max    = 11;
    hold_start    = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    now_time_i    = '0;
    target_slot_i = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset configuration: first window, outside it, invalid slot
    send_query(32'd0, 8'd0);
    send_query(32'd59, 8'd0);
    send_query(32'd60, 8'd1);

    // plain window: each branch of the wait sum, invalid slots, wrap of time
    apply_config(32'd100, 16'd10, 8'd5);
    send_query(32'd0, 8'd0);
    send_query(32'd25, 8'd4);
    send_query(32'd25, 8'd1);
    send_query(32'd25, 8'd5);
    send_query(32'd25, 8'd255);
    send_query(32'd60, 8'd0);
    send_query(32'd130, 8'd2);
    send_query(32'hFFFF_FFFF, 8'd4);
    send_query(32'd200, 8'd0);

    // zero slot length inside a live window
    quiesce();
    write_reg(RegSlotLen, 32'd0);
    send_query(32'd201, 8'd3);
    send_query(32'd213, 8'd4);

    // zero superframe period
    quiesce();
    write_reg(RegPeriod, 32'd0);
    write_reg(RegSlotCnt, 32'd3);
    send_query(32'd5, 8'd2);
    send_query(32'd0, 8'd0);
    send_query(32'hFFFF_FFFF, 8'd2);

    // saturated slot index after shortening slots mid-window
    apply_config(32'd1000, 16'd1000, 8'd200);
    send_query(32'hF000_0000, 8'd0);
    quiesce();
    write_reg(RegSlotLen, 32'd1);
    write_reg(RegSlotCnt, 32'd255);
    send_query(32'd4026682000, 8'd254);
    send_query(32'd4026682000, 8'd255);
    send_query(32'd4026682001, 8'd0);

    // random phases over several settings
    for (int k = 0; k < NumPhases; k++) begin
      cnt = 8'($urandom_range(1, 12));
      len = 16'($urandom_range(1, 20));
      per = $urandom_range(1, 2 * cnt * len + 20);
      case (k)
        0: begin per = 32'hFFFF_FFFF; len = 16'hFFFF; cnt = 8'd255; end
        1: per = 32'd0;
        2: len = 16'd0;
        3: begin per = 32'd1; len = 16'd1; cnt = 8'd1; end
        6: cnt = 8'd0;
        default: ;
      endcase
      apply_config(per, len, cnt);
      tx_gap_max = (k % 3 == 2) ? 0 : 11;
      rx_gap_max = (k % 4 == 1) ? 0 : 11;
      items = (cnt == 0) ? 30 : PhaseItems;
      span = (64'(cnt) * 64'(len)) / 2 + 64'(per) / 8 + 2;
      if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
      t = $urandom();
      if (k == 4) hold_start = 1'b1;
      for (int i = 0; i < items; i++) begin
        if (k == 5 && i == items / 2) drain_results();
        pick = $urandom_range(0, 9);
        case (pick)
          0: now = $urandom();
          1: now = 32'hFFFF_FFFF - $urandom_range(0, 32'(span));
          2: now = t - $urandom_range(0, 32'(span));
          default: begin
            t   = t + $urandom_range(0, 32'(span));
            now = t;
          end
        endcase
        if (cnt == 0 || $urandom_range(0, 4) == 0) slot = 8'($urandom_range(0, 255));
        else slot = 8'($urandom_range(0, cnt - 1));
        send_query(now, slot);
      end
    end

    quiesce();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
